### hdl/m6502x_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m6502x_pkg
// Shared types, operation codes and flag helpers for the 6502 execute unit.
// ----------------------------------------------------------------------------
package m6502x_pkg;

    // Operation numbers, densely packed in decode order.
    typedef enum logic [5:0] {
        CMD_LDA   = 6'd0,  CMD_LDX   = 6'd1,  CMD_LDY   = 6'd2,  CMD_STA   = 6'd3,
        CMD_STX   = 6'd4,  CMD_STY   = 6'd5,  CMD_TAX   = 6'd6,  CMD_TAY   = 6'd7,
        CMD_TSX   = 6'd8,  CMD_TXA   = 6'd9,  CMD_TXS   = 6'd10, CMD_TYA   = 6'd11,
        CMD_ADC   = 6'd12, CMD_SBC   = 6'd13, CMD_DEC   = 6'd14, CMD_DEX   = 6'd15,
        CMD_DEY   = 6'd16, CMD_INC   = 6'd17, CMD_INX   = 6'd18, CMD_INY   = 6'd19,
        CMD_AND   = 6'd20, CMD_ASL_A = 6'd21, CMD_ASL_M = 6'd22, CMD_LSR_A = 6'd23,
        CMD_LSR_M = 6'd24, CMD_ROL_A = 6'd25, CMD_ROL_M = 6'd26, CMD_ROR_A = 6'd27,
        CMD_ROR_M = 6'd28, CMD_BIT   = 6'd29, CMD_EOR   = 6'd30, CMD_ORA   = 6'd31,
        CMD_BCS   = 6'd32, CMD_BCC   = 6'd33, CMD_BEQ   = 6'd34, CMD_BNE   = 6'd35,
        CMD_BMI   = 6'd36, CMD_BPL   = 6'd37, CMD_BVS   = 6'd38, CMD_BVC   = 6'd39,
        CMD_JMP   = 6'd40, CMD_JSR   = 6'd41, CMD_RTI   = 6'd42, CMD_RTS   = 6'd43,
        CMD_CLC   = 6'd44, CMD_SEC   = 6'd45, CMD_CLD   = 6'd46, CMD_SED   = 6'd47,
        CMD_CLI   = 6'd48, CMD_SEI   = 6'd49, CMD_CLV   = 6'd50, CMD_CMP   = 6'd51,
        CMD_CPX   = 6'd52, CMD_CPY   = 6'd53, CMD_PHA   = 6'd54, CMD_PHP   = 6'd55,
        CMD_PLA   = 6'd56, CMD_PLP   = 6'd57, CMD_BRK   = 6'd58
    } cmd_t;

    // Status register bit positions (N V 1 B D I Z C).
    localparam int FLAG_C = 0;
    localparam int FLAG_Z = 1;
    localparam int FLAG_I = 2;
    localparam int FLAG_D = 3;
    localparam int FLAG_B = 4;
    localparam int FLAG_U = 5;
    localparam int FLAG_V = 6;
    localparam int FLAG_N = 7;

    localparam logic [7:0] STACK_PAGE = 8'h01;

    typedef struct packed {
        logic [7:0]  acc;
        logic [7:0]  x;
        logic [7:0]  y;
        logic [7:0]  sp;
        logic [7:0]  p;
        logic [15:0] pc;
    } regs_t;

    localparam regs_t REGS_RESET = '{
        acc: 8'h00, x: 8'h00, y: 8'h00, sp: 8'hFD, p: 8'h24, pc: 16'h0000
    };

    typedef struct packed {
        logic [15:0] addr;
        logic [7:0]  data;
    } wr_t;

    // Everything one operation produces: new registers and up to three writes.
    typedef struct packed {
        regs_t          regs;
        logic [1:0]     wr_count;
        wr_t [3:0]      wr;
    } exec_t;

    function automatic logic [7:0] set_nz(input logic [7:0] p, input logic [7:0] v);
        logic [7:0] q;
        q         = p;
        q[FLAG_Z] = (v == 8'h00);
        q[FLAG_N] = v[7];
        return q;
    endfunction

    function automatic logic [7:0] set_c(input logic [7:0] p, input logic c);
        logic [7:0] q;
        q         = p;
        q[FLAG_C] = c;
        return q;
    endfunction

endpackage

### hdl/m6502x_alu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m6502x_alu
// Single-pass datapath: from the current registers and one decoded operation
// it forms the next register set and the list of memory writes.
// ----------------------------------------------------------------------------
module m6502x_alu (
    input  logic [5:0]          cmd,
    input  logic [7:0]          operand,
    input  logic [15:0]         location,
    input  logic [15:0]         next_pc,
    input  m6502x_pkg::regs_t   regs,
    output m6502x_pkg::exec_t   result
);
    import m6502x_pkg::*;

    localparam logic [1:0] SHIFT_ASL = 2'd0;
    localparam logic [1:0] SHIFT_LSR = 2'd1;
    localparam logic [1:0] SHIFT_ROL = 2'd2;
    localparam logic [1:0] SHIFT_ROR = 2'd3;

    // Returns {carry out, shifted byte}.
    function automatic logic [8:0] shift_fn(input logic [1:0] kind, input logic [7:0] v,
                                            input logic cin);
        logic [8:0] r;
        case (kind)
            SHIFT_ASL: r = {v[7], v[6:0], 1'b0};
            SHIFT_LSR: r = {v[0], 1'b0, v[7:1]};
            SHIFT_ROL: r = {v[7], v[6:0], cin};
            SHIFT_ROR: r = {v[0], cin, v[7:1]};
            default:   r = 9'h000;
        endcase
        return r;
    endfunction

    regs_t       nr;
    logic [1:0]  cnt;
    wr_t [3:0]   wr;
    logic [8:0]  sum;
    logic [8:0]  diff;
    logic [8:0]  sh;
    logic [7:0]  addend;
    logic [7:0]  val;
    logic [7:0]  cmp_left;
    logic [15:0] ret;
    logic [7:0]  sp1;
    logic [7:0]  sp2;
    logic        cin;

    always_comb begin
        nr       = regs;
        nr.pc    = next_pc;
        cnt      = 2'd0;
        wr       = '0;
        cin      = regs.p[FLAG_C];
        addend   = (cmd_t'(cmd) == CMD_SBC) ? ~operand : operand;
        sum      = {1'b0, regs.acc} + {1'b0, addend} + {8'h00, cin};
        case (cmd_t'(cmd))
            CMD_CPX: cmp_left = regs.x;
            CMD_CPY: cmp_left = regs.y;
            default: cmp_left = regs.acc;
        endcase
        diff     = {1'b0, cmp_left} - {1'b0, operand};
        sh       = 9'h000;
        val      = 8'h00;
        ret      = next_pc - 16'd1;
        sp1      = regs.sp - 8'd1;
        sp2      = regs.sp - 8'd2;

        case (cmd_t'(cmd))
            CMD_LDA: begin nr.acc = operand; nr.p = set_nz(regs.p, operand); end
            CMD_LDX: begin nr.x = operand;   nr.p = set_nz(regs.p, operand); end
            CMD_LDY: begin nr.y = operand;   nr.p = set_nz(regs.p, operand); end
            CMD_STA: begin cnt = 2'd1; wr[0] = '{addr: location, data: regs.acc}; end
            CMD_STX: begin cnt = 2'd1; wr[0] = '{addr: location, data: regs.x}; end
            CMD_STY: begin cnt = 2'd1; wr[0] = '{addr: location, data: regs.y}; end
            CMD_TAX: begin nr.x = regs.acc; nr.p = set_nz(regs.p, regs.acc); end
            CMD_TAY: begin nr.y = regs.acc; nr.p = set_nz(regs.p, regs.acc); end
            CMD_TSX: begin nr.x = regs.sp;  nr.p = set_nz(regs.p, regs.sp); end
            CMD_TXA: begin nr.acc = regs.x; nr.p = set_nz(regs.p, regs.x); end
            CMD_TXS: nr.sp = regs.x;
            CMD_TYA: begin nr.acc = regs.y; nr.p = set_nz(regs.p, regs.y); end
            CMD_ADC, CMD_SBC: begin
                nr.acc       = sum[7:0];
                nr.p         = set_nz(set_c(regs.p, sum[8]), sum[7:0]);
                nr.p[FLAG_V] = (regs.acc[7] ^ sum[7]) & (addend[7] ^ sum[7]);
            end
            CMD_DEC: begin
                val   = operand - 8'd1;
                nr.p  = set_nz(regs.p, val);
                cnt   = 2'd1;
                wr[0] = '{addr: location, data: val};
            end
            CMD_INC: begin
                val   = operand + 8'd1;
                nr.p  = set_nz(regs.p, val);
                cnt   = 2'd1;
                wr[0] = '{addr: location, data: val};
            end
            CMD_DEX: begin nr.x = regs.x - 8'd1; nr.p = set_nz(regs.p, nr.x); end
            CMD_DEY: begin nr.y = regs.y - 8'd1; nr.p = set_nz(regs.p, nr.y); end
            CMD_INX: begin nr.x = regs.x + 8'd1; nr.p = set_nz(regs.p, nr.x); end
            CMD_INY: begin nr.y = regs.y + 8'd1; nr.p = set_nz(regs.p, nr.y); end
            CMD_AND: begin nr.acc = regs.acc & operand; nr.p = set_nz(regs.p, nr.acc); end
            CMD_EOR: begin nr.acc = regs.acc ^ operand; nr.p = set_nz(regs.p, nr.acc); end
            CMD_ORA: begin nr.acc = regs.acc | operand; nr.p = set_nz(regs.p, nr.acc); end
            CMD_ASL_A, CMD_LSR_A, CMD_ROL_A, CMD_ROR_A: begin
                // The low command bits after the accumulator form pick the shift kind.
                sh     = shift_fn(2'((cmd - 6'd21) >> 1), regs.acc, cin);
                nr.acc = sh[7:0];
                nr.p   = set_nz(set_c(regs.p, sh[8]), sh[7:0]);
            end
            CMD_ASL_M, CMD_LSR_M, CMD_ROL_M, CMD_ROR_M: begin
                sh    = shift_fn(2'((cmd - 6'd22) >> 1), operand, cin);
                nr.p  = set_nz(set_c(regs.p, sh[8]), sh[7:0]);
                cnt   = 2'd1;
                wr[0] = '{addr: location, data: sh[7:0]};
            end
            CMD_BIT: begin
                nr.p[FLAG_Z] = ((regs.acc & operand) == 8'h00);
                nr.p[FLAG_V] = operand[6];
                nr.p[FLAG_N] = operand[7];
            end
            CMD_BCS: if (regs.p[FLAG_C])  nr.pc = location;
            CMD_BCC: if (!regs.p[FLAG_C]) nr.pc = location;
            CMD_BEQ: if (regs.p[FLAG_Z])  nr.pc = location;
            CMD_BNE: if (!regs.p[FLAG_Z]) nr.pc = location;
            CMD_BMI: if (regs.p[FLAG_N])  nr.pc = location;
            CMD_BPL: if (!regs.p[FLAG_N]) nr.pc = location;
            CMD_BVS: if (regs.p[FLAG_V])  nr.pc = location;
            CMD_BVC: if (!regs.p[FLAG_V]) nr.pc = location;
            CMD_JMP: nr.pc = location;
            CMD_JSR: begin
                cnt   = 2'd2;
                wr[0] = '{addr: {STACK_PAGE, regs.sp}, data: ret[15:8]};
                wr[1] = '{addr: {STACK_PAGE, sp1}, data: ret[7:0]};
                nr.sp = sp2;
                nr.pc = location;
            end
            CMD_RTI: begin
                nr.p         = operand;
                nr.p[FLAG_B] = 1'b0;
                nr.p[FLAG_U] = 1'b1;
                nr.sp        = regs.sp + 8'd3;
                nr.pc        = location;
            end
            CMD_RTS: begin
                nr.sp = regs.sp + 8'd2;
                nr.pc = location + 16'd1;
            end
            CMD_CLC: nr.p[FLAG_C] = 1'b0;
            CMD_SEC: nr.p[FLAG_C] = 1'b1;
            CMD_CLD: nr.p[FLAG_D] = 1'b0;
            CMD_SED: nr.p[FLAG_D] = 1'b1;
            CMD_CLI: nr.p[FLAG_I] = 1'b0;
            CMD_SEI: nr.p[FLAG_I] = 1'b1;
            CMD_CLV: nr.p[FLAG_V] = 1'b0;
            CMD_CMP, CMD_CPX, CMD_CPY: nr.p = set_nz(set_c(regs.p, !diff[8]), diff[7:0]);
            CMD_PHA: begin
                cnt   = 2'd1;
                wr[0] = '{addr: {STACK_PAGE, regs.sp}, data: regs.acc};
                nr.sp = sp1;
            end
            CMD_PHP: begin
                cnt   = 2'd1;
                wr[0] = '{addr: {STACK_PAGE, regs.sp}, data: regs.p | 8'h30};
                nr.sp = sp1;
            end
            CMD_PLA: begin
                nr.sp  = regs.sp + 8'd1;
                nr.acc = operand;
                nr.p   = set_nz(regs.p, operand);
            end
            CMD_PLP: begin
                nr.sp        = regs.sp + 8'd1;
                nr.p         = operand;
                nr.p[FLAG_B] = 1'b0;
                nr.p[FLAG_U] = 1'b1;
            end
            CMD_BRK: begin
                cnt          = 2'd3;
                wr[0]        = '{addr: {STACK_PAGE, regs.sp}, data: next_pc[15:8]};
                wr[1]        = '{addr: {STACK_PAGE, sp1}, data: next_pc[7:0]};
                wr[2]        = '{addr: {STACK_PAGE, sp2}, data: regs.p | 8'h30};
                nr.sp        = regs.sp - 8'd3;
                nr.p[FLAG_I] = 1'b1;
                nr.pc        = location;
            end
            default: ;
        endcase

        result.regs     = nr;
        result.wr_count = cnt;
        result.wr       = wr;
    end

endmodule

### hdl/mos6502_execute_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mos6502_execute_unit
// Execute stage of a 6502 without decimal mode: register file, ALU and the
// output sequencer that emits memory writes followed by a register word.
// ----------------------------------------------------------------------------
// An operation word is captured in an input register and evaluated in one
// combinational pass against the register file. The output register then
// sends one word per cycle unless m_tready holds it: first each memory write
// (stores, read-modify-write results, stack pushes at 0x0100 + SP), then a
// final word with tlast high that carries all registers. The register file is
// updated when that final word is loaded, and the next operation moves up in
// the same cycle. So an operation emits one word more than it has writes: one
// for most, two for stores, read-modify-write ops, pha and php, three for jsr
// and four for brk, all through the single output register.
// ----------------------------------------------------------------------------
module mos6502_execute_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // operand[7:0], location[23:8], next_pc[39:24]
    input  logic [5:0]  s_tuser,   // cmd[5:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,   // write_address[15:0], write_data[23:16], acc_out[31:24],
                                   // x_out[39:32], y_out[47:40], sp_out[55:48],
                                   // flags_out[63:56], pc_out[79:64]
    output logic        m_tuser,   // is_write[0]
    output logic        m_tlast
);
    import m6502x_pkg::*;

    regs_t       regs_reg;
    logic        exec_valid_reg;
    logic [5:0]  exec_cmd_reg;
    logic [39:0] exec_data_reg;
    logic [1:0]  idx_reg;
    logic        m_tvalid_reg;
    logic [79:0] m_tdata_reg;
    logic        m_tuser_reg;
    logic        m_tlast_reg;

    exec_t       result;
    wr_t         cur_wr;
    logic        out_free;
    logic        emit;
    logic        is_final;
    logic        commit;

    m6502x_alu u_alu (
        .cmd      (exec_cmd_reg),
        .operand  (exec_data_reg[7:0]),
        .location (exec_data_reg[23:8]),
        .next_pc  (exec_data_reg[39:24]),
        .regs     (regs_reg),
        .result   (result)
    );

    assign out_free = !m_tvalid_reg || m_tready;
    assign emit     = exec_valid_reg && out_free;
    assign is_final = (idx_reg == result.wr_count);
    assign commit   = emit && is_final;
    assign cur_wr   = result.wr[idx_reg];
    assign s_tready = !exec_valid_reg || commit;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            exec_valid_reg <= 1'b0;
        end else if (s_tready) begin
            exec_valid_reg <= s_tvalid;
        end
        if (s_tready && s_tvalid) begin
            exec_cmd_reg  <= s_tuser;
            exec_data_reg <= s_tdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            regs_reg <= REGS_RESET;
            idx_reg  <= 2'd0;
        end else if (emit) begin
            if (is_final) begin
                regs_reg <= result.regs;
                idx_reg  <= 2'd0;
            end else begin
                idx_reg <= idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (emit) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
        if (emit) begin
            if (is_final) begin
                m_tdata_reg <= {result.regs.pc, result.regs.p, result.regs.sp,
                                result.regs.y, result.regs.x, result.regs.acc, 24'h000000};
                m_tuser_reg <= 1'b0;
                m_tlast_reg <= 1'b1;
            end else begin
                m_tdata_reg <= {56'h0, cur_wr.data, cur_wr.addr};
                m_tuser_reg <= 1'b1;
                m_tlast_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    // The write index never runs past the write count of the held operation.
    a_idx_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        exec_valid_reg |-> (idx_reg <= result.wr_count))
        else $error("write index beyond write count");

    // Sending the final word restarts the write index.
    a_idx_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        commit |=> (idx_reg == 2'd0))
        else $error("write index not cleared after final word");

    // The register file changes only when an operation's final word is sent.
    a_regs_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(aresetn) && !$past(commit)) |-> $stable(regs_reg))
        else $error("registers changed without a completed operation");

    // Stack pushes always land in page one.
    a_push_page: assert property (@(posedge aclk) disable iff (!aresetn)
        (emit && !is_final && (cmd_t'(exec_cmd_reg) == CMD_JSR ||
         cmd_t'(exec_cmd_reg) == CMD_PHA || cmd_t'(exec_cmd_reg) == CMD_PHP ||
         cmd_t'(exec_cmd_reg) == CMD_BRK)) |-> (cur_wr.addr[15:8] == STACK_PAGE))
        else $error("stack push outside the stack page");

endmodule
